// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/owb_pkg.sv =====
package owb_pkg;

   localparam int CNT_W     = 6;
   localparam int BIT_IDX_W = 3;
   localparam int BYTE_W    = 8;
   localparam int PHASE_W   = 4;
   localparam int CMD_W     = 2;
   localparam int ACT_W     = 2;
   localparam int CSR_IDX_W = 3;

   // phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
   localparam logic [PHASE_W-1:0] PH_RST_LOW   = 4'd1;
   localparam logic [PHASE_W-1:0] PH_RST_PRES  = 4'd2;
   localparam logic [PHASE_W-1:0] PH_RST_REC   = 4'd3;
   localparam logic [PHASE_W-1:0] PH_WR_BIT    = 4'd4;
   localparam logic [PHASE_W-1:0] PH_WR_ONE    = 4'd5;
   localparam logic [PHASE_W-1:0] PH_WR_ZERO   = 4'd6;
   localparam logic [PHASE_W-1:0] PH_WR_END    = 4'd7;
   localparam logic [PHASE_W-1:0] PH_RD_SAMPLE = 4'd8;
   localparam logic [PHASE_W-1:0] PH_RD_WAIT   = 4'd9;

   // line actions
   localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_LOW     = 2'd1;
   localparam logic [ACT_W-1:0] ACT_PULSE   = 2'd2;

   // commands
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESET = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRESENCE_WIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RESET_REC     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WRITE_SLOT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_READ_REC      = 3'd4;

   // register reset values
   localparam logic [CNT_W-1:0] DEF_RESET_LOW    = 6'd48;
   localparam logic [CNT_W-1:0] DEF_PRESENCE_WIN = 6'd6;
   localparam logic [CNT_W-1:0] DEF_RESET_REC    = 6'd47;
   localparam logic [CNT_W-1:0] DEF_WRITE_SLOT   = 6'd6;
   localparam logic [CNT_W-1:0] DEF_READ_REC     = 6'd4;

   localparam logic [BIT_IDX_W-1:0] LAST_BIT = 3'd7;

   typedef struct packed {
      logic [CNT_W-1:0] reset_low_ticks;
      logic [CNT_W-1:0] presence_window_ticks;
      logic [CNT_W-1:0] reset_recovery_ticks;
      logic [CNT_W-1:0] write_slot_ticks;
      logic [CNT_W-1:0] read_recovery_ticks;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0]   phase;
      logic [CNT_W-1:0]     tick_counter;
      logic [BIT_IDX_W-1:0] bit_index;
      logic [BYTE_W-1:0]    shift_byte;
      logic [BYTE_W-1:0]    bytes_left;
   } state_type;

   typedef struct packed {
      logic [ACT_W-1:0]  line_action;
      logic              busy_res;
      logic              op_done;
      logic              status;
      logic              read_valid;
      logic [BYTE_W-1:0] read_byte;
      logic              read_last;
   } result_type;

endpackage

// ===== hw/rtl/owb_step.sv =====
module owb_step
   import owb_pkg::*;
(
   input  state_type         cur,
   input  cfg_type           cfg,
   input  logic [CMD_W-1:0]  command,
   input  logic [BYTE_W-1:0] operand,
   input  logic              line_level,
   output state_type         nxt,
   output result_type        res
);

   logic [CNT_W-1:0]     cnt_dec;
   logic                 expired;
   logic [BIT_IDX_W-1:0] bit_inc;
   logic [BYTE_W-1:0]    bytes_dec;

   assign cnt_dec   = cur.tick_counter - CNT_W'(1);
   assign expired   = (cnt_dec == '0);
   assign bit_inc   = cur.bit_index + BIT_IDX_W'(1);
   assign bytes_dec = cur.bytes_left - BYTE_W'(1);

   always_comb begin
      nxt = cur;
      res = '0;
      res.line_action = ACT_RELEASE;
      case (cur.phase)
         PH_RST_LOW: begin
            nxt.tick_counter = cnt_dec;
            if (expired) begin
               nxt.tick_counter = cfg.presence_window_ticks;
               nxt.phase = PH_RST_PRES;
            end else begin
               res.line_action = ACT_LOW;
            end
         end
         PH_RST_PRES: begin
            nxt.tick_counter = cnt_dec;
            // a low level counts as presence even in the last window tick
            if (!line_level) begin
               nxt.tick_counter = cfg.reset_recovery_ticks;
               nxt.phase = PH_RST_REC;
            end else if (expired) begin
               nxt.phase = PH_IDLE;
               res.op_done = 1'b1;
               res.status = 1'b1;
            end
         end
         PH_RST_REC: begin
            nxt.tick_counter = cnt_dec;
            if (expired) begin
               nxt.phase = PH_IDLE;
               res.op_done = 1'b1;
            end
         end
         PH_WR_BIT: begin
            nxt.tick_counter = cfg.write_slot_ticks;
            if (cur.shift_byte[cur.bit_index]) begin
               nxt.phase = PH_WR_ONE;
               res.line_action = ACT_PULSE;
            end else begin
               nxt.phase = PH_WR_ZERO;
               res.line_action = ACT_LOW;
            end
         end
         PH_WR_ONE: begin
            nxt.tick_counter = cnt_dec;
            if (expired) nxt.phase = PH_WR_END;
         end
         PH_WR_ZERO: begin
            nxt.tick_counter = cnt_dec;
            if (expired) nxt.phase = PH_WR_END;
            else res.line_action = ACT_LOW;
         end
         PH_WR_END: begin
            if (cur.bit_index == LAST_BIT) begin
               nxt.phase = PH_IDLE;
               res.op_done = 1'b1;
            end else begin
               // next bit slot starts right away
               nxt.bit_index = bit_inc;
               nxt.tick_counter = cfg.write_slot_ticks;
               if (cur.shift_byte[bit_inc]) begin
                  nxt.phase = PH_WR_ONE;
                  res.line_action = ACT_PULSE;
               end else begin
                  nxt.phase = PH_WR_ZERO;
                  res.line_action = ACT_LOW;
               end
            end
         end
         PH_RD_SAMPLE: begin
            if (line_level) nxt.shift_byte[cur.bit_index] = 1'b1;
            nxt.tick_counter = cfg.read_recovery_ticks;
            nxt.phase = PH_RD_WAIT;
         end
         PH_RD_WAIT: begin
            nxt.tick_counter = cnt_dec;
            if (expired) begin
               nxt.phase = PH_RD_SAMPLE;
               res.line_action = ACT_PULSE;
               if (cur.bit_index == LAST_BIT) begin
                  res.read_valid = 1'b1;
                  res.read_byte = cur.shift_byte;
                  nxt.bytes_left = bytes_dec;
                  nxt.shift_byte = '0;
                  nxt.bit_index = '0;
                  if (bytes_dec == '0) begin
                     res.read_last = 1'b1;
                     res.op_done = 1'b1;
                     res.line_action = ACT_RELEASE;
                     nxt.phase = PH_IDLE;
                  end
               end else begin
                  nxt.bit_index = bit_inc;
               end
            end
         end
         default: begin
            // idle, and unreachable codes behave as idle
            nxt.phase = PH_IDLE;
            case (command)
               CMD_RESET: begin
                  nxt.tick_counter = cfg.reset_low_ticks;
                  nxt.phase = PH_RST_LOW;
                  res.line_action = ACT_LOW;
               end
               CMD_WRITE: begin
                  nxt.shift_byte = operand;
                  nxt.bit_index = '0;
                  nxt.phase = PH_WR_BIT;
               end
               CMD_READ: begin
                  nxt.bytes_left = operand;
                  nxt.shift_byte = '0;
                  nxt.bit_index = '0;
                  nxt.phase = PH_RD_SAMPLE;
                  res.line_action = ACT_PULSE;
               end
               default: begin
               end
            endcase
         end
      endcase
      res.busy_res = (nxt.phase != PH_IDLE);
   end

endmodule

// ===== hw/rtl/one_wire_bus_master.sv =====
// 1-Wire bus master stepped once per bus tick. Every accepted req item is one
// tick: it carries the sampled line level and, while the master is idle, may
// start a reset with presence detect, a one-byte write or an n-byte read
// (operand 0 reads 256 bytes). Each item yields exactly one rsp item telling
// how to drive the line in that tick, plus done, status and read byte flags.
// One item per clock is taken: the phase/counter state updates in the cycle of
// acceptance and the result lands in an output register, so req_stall is only
// raised while a held rsp item is stalled. Timing registers are written over
// the csr port (always ready); the user must write them only while no
// operation is running (not enforced here); a value of 0 counts as 64 ticks.
`include "assert_macros.svh"

module one_wire_bus_master
   import owb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [BYTE_W-1:0]    req_operand,
   input  logic                 req_line_level,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ACT_W-1:0]     rsp_line_action,
   output logic                 rsp_busy_res,
   output logic                 rsp_op_done,
   output logic                 rsp_status,
   output logic                 rsp_read_valid,
   output logic [BYTE_W-1:0]    rsp_read_byte,
   output logic                 rsp_read_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_data
);

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in;
   result_type res_ff, res_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_RESET_LOW:    cfg_in.reset_low_ticks       = csr_data;
            REG_PRESENCE_WIN: cfg_in.presence_window_ticks = csr_data;
            REG_RESET_REC:    cfg_in.reset_recovery_ticks  = csr_data;
            REG_WRITE_SLOT:   cfg_in.write_slot_ticks      = csr_data;
            REG_READ_REC:     cfg_in.read_recovery_ticks   = csr_data;
            default: begin
            end
         endcase
      end
   end

   owb_step u_step (
      .cur        (state_ff),
      .cfg        (cfg_ff),
      .command    (req_command),
      .operand    (req_operand),
      .line_level (req_line_level),
      .nxt        (state_in),
      .res        (res_in)
   );

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks       <= DEF_RESET_LOW;
         cfg_ff.presence_window_ticks <= DEF_PRESENCE_WIN;
         cfg_ff.reset_recovery_ticks  <= DEF_RESET_REC;
         cfg_ff.write_slot_ticks      <= DEF_WRITE_SLOT;
         cfg_ff.read_recovery_ticks   <= DEF_READ_REC;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) state_ff <= state_in;
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) res_ff <= res_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_line_action = res_ff.line_action;
   assign rsp_busy_res    = res_ff.busy_res;
   assign rsp_op_done     = res_ff.op_done;
   assign rsp_status      = res_ff.status;
   assign rsp_read_valid  = res_ff.read_valid;
   assign rsp_read_byte   = res_ff.read_byte;
   assign rsp_read_last   = res_ff.read_last;

   // busy flag of the delivered item tracks the phase it left behind
   `ASSERT_CLK(a_busy_matches_phase, clock, reset,
      accept |=> (rsp_busy_res == (state_ff.phase != PH_IDLE)), "busy flag disagrees with phase")
   `ASSERT_IMPLY(a_last_ends_op, clock, reset, rsp_valid && rsp_read_last,
      rsp_op_done && rsp_read_valid && !rsp_busy_res, "last read byte without end of operation")
   `ASSERT_IMPLY(a_status_on_done, clock, reset, rsp_valid && rsp_status,
      rsp_op_done && !rsp_read_valid, "status raised outside a finished reset")
   `ASSERT_CLK(a_idle_tick_stays_idle, clock, reset,
      (accept && state_ff.phase == PH_IDLE && req_command == CMD_TICK)
      |=> (state_ff.phase == PH_IDLE), "plain tick left idle")

endmodule
